FILE: design/gsls_pkg.sv
// ----------------------------------------------------------------------------
// gsls_pkg
// Shared types and constants of the Gauss-Seidel solver: field widths,
// register indexes, status codes and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package gsls_pkg;

    // fixed field widths
    localparam int COEF_W  = 32;   // coefficient, Q16.16
    localparam int ACC_W   = 64;   // accumulator, Q32.32
    localparam int SIZE_W  = 4;
    localparam int LIMIT_W = 16;
    localparam int TOL_W   = 16;
    localparam int STAT_W  = 2;
    localparam int FRAC_W  = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYSTEM_SIZE = 2'd0,
        CFG_ITER_LIMIT  = 2'd1,
        CFG_TOLERANCE   = 2'd2
    } t_cfg_idx;

    // register reset values
    localparam logic [SIZE_W-1:0]  RST_SIZE  = 4'd3;
    localparam logic [LIMIT_W-1:0] RST_LIMIT = 16'd1000;
    localparam logic [TOL_W-1:0]   RST_TOL   = 16'd328;

    // parameter defaults
    localparam int DEF_MAX_EQ  = 8;
    localparam int DEF_VALUE_W = 32;

    // 100 * 2^16: percent scale times the Q16.16 scale of the tolerance
    localparam int               SCALE_W   = 23;
    localparam logic [SCALE_W-1:0] TOL_SCALE = 23'd6553600;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_CONVERGED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_LIMIT     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SINGULAR  = 2'd2;

    // controller -> datapath commands
    typedef struct packed {
        logic store_we;   // write input word to the coefficient store
        logic acc_init;   // acc <= b << 16
        logic lat_div;    // latch diagonal as divisor
        logic mul;        // prod <= a_ij * x_j
        logic acc_add;    // acc <= sat(acc - prod)
        logic div_go;     // start divider
        logic tol_calc;   // saturate quotient, form tolerance terms
        logic x_upd;      // write new unknown
        logic x_clr;      // clear all unknowns
        logic out_load;   // load output word
    } t_dp_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic rd_zero;    // read data is zero
        logic div_done;   // divider finished (pulse)
        logic changed;    // unknown moved beyond tolerance
        logic out_free;   // output register can take a word
    } t_dp_stat;

endpackage

FILE: design/gsls_div.sv
// ----------------------------------------------------------------------------
// gsls_div
// Radix-2 restoring divider, signed 64 / 32, quotient truncated toward zero.
// One quotient bit per cycle; done is registered together with the last bit.
// ----------------------------------------------------------------------------
module gsls_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [gsls_pkg::ACC_W-1:0]  i_dividend,
    input  logic signed [gsls_pkg::COEF_W-1:0] i_divisor,
    output logic                               o_done,
    output logic signed [gsls_pkg::ACC_W-1:0]  o_quot
);
    import gsls_pkg::*;

    localparam int CNT_W = $clog2(ACC_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [COEF_W-1:0]   r_rem;
    logic [ACC_W-1:0]    r_dvd;
    logic [COEF_W-1:0]   r_dsr;
    logic                r_neg;

    logic [COEF_W:0]     w_trial;
    logic                w_fit;

    // trial subtract of the next partial remainder
    assign w_trial = {r_rem, r_dvd[ACC_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dsr});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ACC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // magnitudes and shift/subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend[ACC_W-1] ? ACC_W'(-i_dividend) : ACC_W'(i_dividend);
            r_dsr <= i_divisor[COEF_W-1] ? COEF_W'(-i_divisor) : COEF_W'(i_divisor);
            r_neg <= i_dividend[ACC_W-1] ^ i_divisor[COEF_W-1];
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_fit ? COEF_W'(w_trial - {1'b0, r_dsr}) : w_trial[COEF_W-1:0];
            r_dvd <= {r_dvd[ACC_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_dvd) : $signed(r_dvd);

endmodule

FILE: design/gsls_dp.sv
// ----------------------------------------------------------------------------
// gsls_dp
// Solver datapath: coefficient store, unknowns, multiply-accumulate,
// divider, tolerance test and the output word register.
// ----------------------------------------------------------------------------
module gsls_dp #(
    parameter int MAX_EQUATIONS = gsls_pkg::DEF_MAX_EQ,
    parameter int VALUE_WIDTH   = gsls_pkg::DEF_VALUE_W,
    localparam int DEPTH  = MAX_EQUATIONS * (MAX_EQUATIONS + 1),
    localparam int AW     = $clog2(DEPTH),
    localparam int IDX_W  = $clog2(MAX_EQUATIONS),
    localparam int OUT_B  = IDX_W + gsls_pkg::COEF_W + gsls_pkg::STAT_W + gsls_pkg::LIMIT_W,
    localparam int DATA_W = (OUT_B + 7) / 8 * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gsls_pkg::t_dp_cmd                   i_cmd,
    output gsls_pkg::t_dp_stat                  o_stat,
    input  logic [AW-1:0]                       i_wr_addr,
    input  logic [AW-1:0]                       i_rd_addr,
    input  logic [IDX_W-1:0]                    i_x_addr,
    input  logic signed [gsls_pkg::COEF_W-1:0]  i_coef,
    input  logic [gsls_pkg::TOL_W-1:0]          i_tol,
    input  logic [gsls_pkg::STAT_W-1:0]         i_out_status,
    input  logic [gsls_pkg::LIMIT_W-1:0]        i_out_sweeps,
    input  logic                                i_out_last,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [DATA_W-1:0]                   o_m_tdata,
    output logic                                o_m_tlast
);
    import gsls_pkg::*;

    localparam int SAT_W = (VALUE_WIDTH > COEF_W) ? COEF_W : VALUE_WIDTH;
    localparam logic signed [ACC_W-1:0] Q_HI    = (ACC_W'(1) << (SAT_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] Q_LO    = -Q_HI - ACC_W'(1);
    localparam logic signed [ACC_W:0]   ACC_MAX = {2'b00, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W:0]   ACC_MIN = -ACC_MAX;

    logic signed [COEF_W-1:0] r_mem [DEPTH];
    logic signed [COEF_W-1:0] r_rdata;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [COEF_W-1:0] r_dsr;
    logic signed [ACC_W-1:0]  r_prod;
    logic signed [SAT_W-1:0]  r_x [MAX_EQUATIONS];
    logic signed [SAT_W-1:0]  r_q;
    logic [ACC_W-1:0]         r_left;
    logic [ACC_W-1:0]         r_right;
    logic                     r_tvalid;
    logic [DATA_W-1:0]        r_tdata;
    logic                     r_tlast;

    logic signed [SAT_W-1:0]  w_x;
    logic signed [ACC_W:0]    w_sum;
    logic signed [ACC_W-1:0]  w_quot;
    logic                     w_div_done;
    logic signed [SAT_W-1:0]  w_qsat;
    logic signed [SAT_W:0]    w_diff;
    logic [SAT_W:0]           w_dmag;
    logic [SAT_W:0]           w_qmag;

    // coefficient store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_we) begin
            r_mem[i_wr_addr] <= i_coef;
        end
        r_rdata <= r_mem[i_rd_addr];
    end

    assign w_x = r_x[i_x_addr];

    // saturating accumulate of -a_ij*x_j
    assign w_sum = $signed({r_acc[ACC_W-1], r_acc}) - $signed({r_prod[ACC_W-1], r_prod});

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_init) begin
            r_acc <= ACC_W'($signed({r_rdata, {FRAC_W{1'b0}}}));
        end else if (i_cmd.acc_add) begin
            if (w_sum > ACC_MAX)      r_acc <= ACC_MAX[ACC_W-1:0];
            else if (w_sum < ACC_MIN) r_acc <= ACC_MIN[ACC_W-1:0];
            else                      r_acc <= w_sum[ACC_W-1:0];
        end
        if (i_cmd.lat_div) begin
            r_dsr <= r_rdata;
        end
        if (i_cmd.mul) begin
            r_prod <= r_rdata * COEF_W'(w_x);
        end
    end

    gsls_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (r_acc),
        .i_divisor  (r_dsr),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // saturate quotient and form both sides of the tolerance test
    always_comb begin
        if (w_quot > Q_HI)      w_qsat = Q_HI[SAT_W-1:0];
        else if (w_quot < Q_LO) w_qsat = Q_LO[SAT_W-1:0];
        else                    w_qsat = w_quot[SAT_W-1:0];
        w_diff = (SAT_W+1)'(w_qsat) - (SAT_W+1)'(w_x);
        w_dmag = w_diff[SAT_W] ? (SAT_W+1)'(-w_diff) : (SAT_W+1)'(w_diff);
        w_qmag = w_qsat[SAT_W-1] ? (SAT_W+1)'(-(SAT_W+1)'(w_qsat))
                                 : (SAT_W+1)'(w_qsat);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tol_calc) begin
            r_q     <= w_qsat;
            r_left  <= ACC_W'(w_dmag) * ACC_W'(TOL_SCALE);
            r_right <= ACC_W'(i_tol) * ACC_W'(w_qmag);
        end
    end

    // unknowns
    always_ff @(posedge i_clk) begin
        if (i_cmd.x_clr) begin
            for (int k = 0; k < MAX_EQUATIONS; k++) begin
                r_x[k] <= '0;
            end
        end else if (i_cmd.x_upd) begin
            r_x[i_x_addr] <= r_q;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_tdata <= DATA_W'({i_out_sweeps, i_out_status, COEF_W'(w_x), i_x_addr});
            r_tlast <= i_out_last;
        end
    end

    assign o_stat.rd_zero  = (r_rdata == '0);
    assign o_stat.div_done = w_div_done;
    assign o_stat.changed  = (r_left > r_right);
    assign o_stat.out_free = !r_tvalid || i_m_tready;

    assign o_m_tvalid = r_tvalid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tlast  = r_tlast;

endmodule

FILE: design/gsls_ctrl.sv
// ----------------------------------------------------------------------------
// gsls_ctrl
// Solver sequencer: load counter, diagonal rotation search, sweep, row and
// column counters, convergence decision and result emission.
// ----------------------------------------------------------------------------
module gsls_ctrl #(
    parameter int MAX_EQUATIONS = gsls_pkg::DEF_MAX_EQ,
    localparam int DEPTH = MAX_EQUATIONS * (MAX_EQUATIONS + 1),
    localparam int AW    = $clog2(DEPTH),
    localparam int PW    = $clog2(DEPTH + 1),
    localparam int NW    = $clog2(MAX_EQUATIONS + 1),
    localparam int IDX_W = $clog2(MAX_EQUATIONS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [NW-1:0]                 i_n_eq,
    input  logic [gsls_pkg::LIMIT_W-1:0]  i_limit,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    output gsls_pkg::t_dp_cmd             o_cmd,
    input  gsls_pkg::t_dp_stat            i_stat,
    output logic [AW-1:0]                 o_wr_addr,
    output logic [AW-1:0]                 o_rd_addr,
    output logic [IDX_W-1:0]              o_x_addr,
    output logic [gsls_pkg::STAT_W-1:0]   o_out_status,
    output logic [gsls_pkg::LIMIT_W-1:0]  o_out_sweeps,
    output logic                          o_out_last
);
    import gsls_pkg::*;

    localparam int TW = 2 * NW + 1;

    typedef enum logic [13:0] {
        S_LOAD     = 14'b00000000000001,
        S_ROT_RD   = 14'b00000000000010,
        S_ROT_CHK  = 14'b00000000000100,
        S_RD_B     = 14'b00000000001000,
        S_RD_D     = 14'b00000000010000,
        S_LAT_D    = 14'b00000000100000,
        S_COL      = 14'b00000001000000,
        S_MUL      = 14'b00000010000000,
        S_ACC      = 14'b00000100000000,
        S_DIV_GO   = 14'b00001000000000,
        S_DIV_WAIT = 14'b00010000000000,
        S_TOL      = 14'b00100000000000,
        S_UPD      = 14'b01000000000000,
        S_EMIT     = 14'b10000000000000
    } t_state;

    t_state              r_state, n_state;
    logic [PW-1:0]       r_pos, n_pos;
    logic [NW-1:0]       r_row, n_row;
    logic [NW-1:0]       r_col, n_col;
    logic [NW-1:0]       r_rot, n_rot;
    logic [LIMIT_W-1:0]  r_sweep, n_sweep;
    logic [NW-1:0]       r_chg, n_chg;
    logic [STAT_W-1:0]   r_status, n_status;

    logic [NW-1:0]       w_last;
    logic [TW-1:0]       w_total;
    logic                w_accept;
    logic [NW:0]         w_psum;
    logic [NW-1:0]       w_phys;
    logic [NW-1:0]       w_rcol;
    logic [TW-1:0]       w_idx;
    logic [NW-1:0]       w_chg_nxt;
    logic [LIMIT_W-1:0]  w_sweep_nxt;
    logic [LIMIT_W-1:0]  w_limit;

    assign w_last      = NW'(i_n_eq - NW'(1));
    assign w_total     = TW'(i_n_eq) * TW'(i_n_eq + NW'(1));
    assign w_accept    = i_s_tvalid && (r_state == S_LOAD);
    assign w_chg_nxt   = r_chg + NW'(i_stat.changed);
    assign w_sweep_nxt = r_sweep + LIMIT_W'(1);
    assign w_limit     = (i_limit == '0) ? LIMIT_W'(1) : i_limit;

    // store address of (row, col) under the current rotation
    always_comb begin
        w_psum = (NW+1)'(r_row) + (NW+1)'(r_rot);
        w_phys = (w_psum >= (NW+1)'(i_n_eq)) ? NW'(w_psum - (NW+1)'(i_n_eq))
                                              : w_psum[NW-1:0];
        case (r_state)
            S_RD_B:                     w_rcol = i_n_eq;
            S_ROT_RD, S_RD_D:           w_rcol = r_row;
            default:                    w_rcol = r_col;
        endcase
        w_idx = TW'(w_phys) * TW'(i_n_eq + NW'(1)) + TW'(w_rcol);
    end

    // next state and counters
    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_row    = r_row;
        n_col    = r_col;
        n_rot    = r_rot;
        n_sweep  = r_sweep;
        n_chg    = r_chg;
        n_status = r_status;
        o_cmd    = '0;

        case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    o_cmd.store_we = (TW'(r_pos) < w_total);
                    if (TW'(r_pos) + TW'(1) >= w_total) begin
                        o_cmd.x_clr = 1'b1;
                        n_pos   = '0;
                        n_sweep = '0;
                        n_chg   = '0;
                        n_rot   = '0;
                        n_row   = '0;
                        n_state = S_ROT_RD;
                    end else begin
                        n_pos = r_pos + PW'(1);
                    end
                end
            end
            S_ROT_RD: n_state = S_ROT_CHK;
            S_ROT_CHK: begin
                if (i_stat.rd_zero) begin
                    n_row = '0;
                    if (r_rot == w_last) begin
                        n_status = STAT_SINGULAR;
                        n_state  = S_EMIT;
                    end else begin
                        n_rot   = r_rot + NW'(1);
                        n_state = S_ROT_RD;
                    end
                end else if (r_row == w_last) begin
                    n_row   = '0;
                    n_state = S_RD_B;
                end else begin
                    n_row   = r_row + NW'(1);
                    n_state = S_ROT_RD;
                end
            end
            S_RD_B: n_state = S_RD_D;
            S_RD_D: begin
                o_cmd.acc_init = 1'b1;
                n_state = S_LAT_D;
            end
            S_LAT_D: begin
                o_cmd.lat_div = 1'b1;
                n_col   = '0;
                n_state = S_COL;
            end
            S_COL: begin
                if (r_col == i_n_eq)     n_state = S_DIV_GO;
                else if (r_col == r_row) n_col = r_col + NW'(1);
                else                     n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_col   = r_col + NW'(1);
                n_state = S_COL;
            end
            S_DIV_GO: begin
                o_cmd.div_go = 1'b1;
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) n_state = S_TOL;
            end
            S_TOL: begin
                o_cmd.tol_calc = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.x_upd = 1'b1;
                if (r_row == w_last) begin
                    n_sweep = w_sweep_nxt;
                    n_row   = '0;
                    if ((w_chg_nxt != '0) && (w_sweep_nxt < w_limit)) begin
                        n_chg   = '0;
                        n_state = S_RD_B;
                    end else begin
                        n_chg    = w_chg_nxt;
                        n_status = (w_chg_nxt != '0) ? STAT_LIMIT : STAT_CONVERGED;
                        n_state  = S_EMIT;
                    end
                end else begin
                    n_chg   = w_chg_nxt;
                    n_row   = r_row + NW'(1);
                    n_state = S_RD_B;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_row == w_last) begin
                        n_row   = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_row = r_row + NW'(1);
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_pos    <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_rot    <= '0;
            r_sweep  <= '0;
            r_chg    <= '0;
            r_status <= STAT_CONVERGED;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_row    <= n_row;
            r_col    <= n_col;
            r_rot    <= n_rot;
            r_sweep  <= n_sweep;
            r_chg    <= n_chg;
            r_status <= n_status;
        end
    end

    assign o_s_tready   = (r_state == S_LOAD);
    assign o_wr_addr    = r_pos[AW-1:0];
    assign o_rd_addr    = w_idx[AW-1:0];
    assign o_x_addr     = (r_state == S_MUL) ? r_col[IDX_W-1:0] : r_row[IDX_W-1:0];
    assign o_out_status = r_status;
    assign o_out_sweeps = r_sweep;
    assign o_out_last   = (r_row == w_last);

`ifndef SYNTHESIS
    // a word is only loaded when the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("output word loaded while register full");

    // every accumulate follows its product
    a_acc_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.acc_add |-> $past(o_cmd.mul))
        else $error("accumulate without a fresh product");

    // an unknown is written only right after its tolerance terms
    a_upd_after_tol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.x_upd |-> $past(o_cmd.tol_calc))
        else $error("unknown written without tolerance step");

    // the sweep count never passes the limit
    a_sweep_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_sweep <= w_limit))
        else $error("sweep count beyond iteration limit");
`endif

endmodule

FILE: design/gauss_seidel_linear_solver_core.sv
// Load: one coefficient per cycle while tvalid is high; solve starts after the last.
// Rotation search: each diagonal read passes through S_ROT_RD and S_ROT_CHK.
// Sweep: the divider dominates the time spent on each row.
// Results: n words, one per cycle when the sink is ready; the next load starts after.
// Reset (synchronous, active low) restores registers to 3, 1000, 328 and idles.
// ----------------------------------------------------------------------------
// gauss_seidel_linear_solver_core
// Gauss-Seidel solver for up to MAX_EQUATIONS equations: streamed augmented
// matrix in, one result word per unknown out, with status and sweep count.
// ----------------------------------------------------------------------------
module gauss_seidel_linear_solver_core #(
    parameter int MAX_EQUATIONS = gsls_pkg::DEF_MAX_EQ,
    parameter int VALUE_WIDTH   = gsls_pkg::DEF_VALUE_W,
    localparam int IDX_W  = $clog2(MAX_EQUATIONS),
    localparam int OUT_B  = IDX_W + gsls_pkg::COEF_W + gsls_pkg::STAT_W + gsls_pkg::LIMIT_W,
    localparam int DATA_W = (OUT_B + 7) / 8 * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [gsls_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [gsls_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [gsls_pkg::COEF_W-1:0]        i_s_tdata,   // coef_value
    // output stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [DATA_W-1:0]                  o_m_tdata,   // var_index, var_value,
                                                            // solve_status, sweeps_used
    output logic                               o_m_tlast    // last_of_run
);
    import gsls_pkg::*;

    localparam int DEPTH = MAX_EQUATIONS * (MAX_EQUATIONS + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_EQUATIONS + 1);
    localparam int CW    = (NW > SIZE_W) ? NW : SIZE_W;

    logic [SIZE_W-1:0]  r_size;
    logic [LIMIT_W-1:0] r_limit;
    logic [TOL_W-1:0]   r_tol;

    logic [CW-1:0]      w_size_ext;
    logic [NW-1:0]      w_n_eq;
    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic [AW-1:0]      w_wr_addr;
    logic [AW-1:0]      w_rd_addr;
    logic [IDX_W-1:0]   w_x_addr;
    logic [STAT_W-1:0]  w_out_status;
    logic [LIMIT_W-1:0] w_out_sweeps;
    logic               w_out_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= RST_SIZE;
            r_limit <= RST_LIMIT;
            r_tol   <= RST_TOL;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SYSTEM_SIZE: r_size  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_ITER_LIMIT:  r_limit <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_TOLERANCE:   r_tol   <= i_cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // equation count clamped to 1 .. MAX_EQUATIONS
    always_comb begin
        w_size_ext = CW'(r_size);
        if (w_size_ext == '0)                        w_n_eq = NW'(1);
        else if (w_size_ext > CW'(MAX_EQUATIONS))    w_n_eq = NW'(MAX_EQUATIONS);
        else                                         w_n_eq = NW'(w_size_ext);
    end

    gsls_ctrl #(
        .MAX_EQUATIONS (MAX_EQUATIONS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_n_eq       (w_n_eq),
        .i_limit      (r_limit),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .o_cmd        (w_cmd),
        .i_stat       (w_stat),
        .o_wr_addr    (w_wr_addr),
        .o_rd_addr    (w_rd_addr),
        .o_x_addr     (w_x_addr),
        .o_out_status (w_out_status),
        .o_out_sweeps (w_out_sweeps),
        .o_out_last   (w_out_last)
    );

    gsls_dp #(
        .MAX_EQUATIONS (MAX_EQUATIONS),
        .VALUE_WIDTH   (VALUE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_wr_addr    (w_wr_addr),
        .i_rd_addr    (w_rd_addr),
        .i_x_addr     (w_x_addr),
        .i_coef       ($signed(i_s_tdata)),
        .i_tol        (r_tol),
        .i_out_status (w_out_status),
        .i_out_sweeps (w_out_sweeps),
        .i_out_last   (w_out_last),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tlast    (o_m_tlast)
    );

endmodule
